@@ src/nps_pkg.sv @@
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types, constants and opcodes of the nearest point search unit.
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 16;

    localparam int INDEX_BITS = $clog2(MAX_POINTS);
    localparam int COUNT_BITS = $clog2(MAX_POINTS + 1);
    localparam int POINT_BITS = 3 * COORD_BITS;
    localparam int MAG_BITS   = COORD_BITS;          // |a - b| never exceeds 2^COORD_BITS - 1
    localparam int SQ_BITS    = 2 * MAG_BITS;
    localparam int SUM_BITS   = SQ_BITS + 2;
    localparam int DIST_BITS  = 36;
    localparam int DIMS_BITS  = 2;
    localparam int OP_BITS    = 2;

    // Opcodes
    localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_DIMENSIONS = 1'b0;
    localparam logic CFG_CEILING    = 1'b1;

    localparam logic [DIMS_BITS-1:0] DIMS_RESET    = 2'd3;
    localparam logic [DIST_BITS-1:0] CEILING_RESET = 36'd1677721600;

    typedef struct packed {
        logic [OP_BITS-1:0]           opcode;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
    } t_in_word;

    typedef struct packed {
        logic [INDEX_BITS-1:0] nearest_index;
        logic [DIST_BITS-1:0]  best_distance;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic load_query;
        logic rd_issue;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic last_addr;
        logic pipe_busy;
    } t_sts;

endpackage

@@ src/nps_ram.sv @@
// ----------------------------------------------------------------------------
// nps_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module nps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/nps_ctrl.sv @@
// ----------------------------------------------------------------------------
// nps_ctrl
// Controller: input handshake, query sequencing and output word valid.
// ----------------------------------------------------------------------------
module nps_ctrl
    import nps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [OP_BITS-1:0] i_opcode,
    output logic               o_valid,
    input  logic               i_stall,
    output t_cmd               o_cmd,
    input  t_sts               i_sts
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_accept;
    logic       out_free;
    t_cmd       cmd;

    assign in_accept = i_valid && (r_state == S_IDLE);
    assign out_free  = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        cmd         = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (i_opcode)
                        OP_CLEAR:  cmd.clear  = 1'b1;
                        OP_APPEND: cmd.append = 1'b1;
                        OP_QUERY: begin
                            cmd.load_query = 1'b1;
                            n_state        = i_sts.empty ? S_DONE : S_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                cmd.rd_issue = 1'b1;
                if (i_sts.last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !(r_out_valid && i_stall))
        else $error("result loaded over a stalled output word");

    a_done_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !i_sts.pipe_busy)
        else $error("result ready while the distance pipeline still runs");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> r_out_valid)
        else $error("output word not marked valid after load");
`endif

endmodule

@@ src/nps_dp.sv @@
// ----------------------------------------------------------------------------
// nps_dp
// Datapath: point table, scan address, distance pipeline, best tracking.
// ----------------------------------------------------------------------------
module nps_dp
    import nps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_in_word             i_word,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [DIMS_BITS-1:0] i_dims,
    input  logic [DIST_BITS-1:0] i_ceiling,
    output t_out_word            o_word
);

    logic [COUNT_BITS-1:0] r_count;
    logic [INDEX_BITS-1:0] r_addr;
    logic                  full;
    logic                  wr_en;
    logic [POINT_BITS-1:0] rd_data;

    logic signed [COORD_BITS-1:0] r_qx, r_qy, r_qz;

    // pipeline valids and indexes: 1 RAM out, 2 magnitudes, 3 squares, 4 sum
    logic                  r_v1, r_v2, r_v3, r_v4;
    logic [INDEX_BITS-1:0] r_idx1, r_idx2, r_idx3, r_idx4;
    logic [MAG_BITS-1:0]   r_mag_x, r_mag_y, r_mag_z;
    logic [SQ_BITS-1:0]    r_sq_x, r_sq_y, r_sq_z;
    logic [SUM_BITS-1:0]   r_sum;

    logic [DIST_BITS-1:0]  r_best;
    logic [INDEX_BITS-1:0] r_best_idx;
    t_out_word             r_out;

    logic signed [COORD_BITS-1:0] px, py, pz;
    logic [MAG_BITS-1:0]          mag_x, mag_y, mag_z;
    logic                         use_y, use_z;
    logic [SUM_BITS-1:0]          sum;
    logic [DIST_BITS-1:0]         sum_ext;

    function automatic logic [MAG_BITS-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] d;
        logic        [COORD_BITS:0] m;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[COORD_BITS] ? (~d + 1'b1) : d;
        return m[MAG_BITS-1:0];
    endfunction

    assign full  = (r_count == COUNT_BITS'(MAX_POINTS));
    assign wr_en = i_cmd.append && !full;

    nps_ram #(
        .WIDTH (POINT_BITS),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[INDEX_BITS-1:0]),
        .i_wr_data ({i_word.coord_x, i_word.coord_y, i_word.coord_z}),
        .i_rd_en   (i_cmd.rd_issue),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    assign px = rd_data[3*COORD_BITS-1:2*COORD_BITS];
    assign py = rd_data[2*COORD_BITS-1:COORD_BITS];
    assign pz = rd_data[COORD_BITS-1:0];

    assign mag_x = abs_diff(r_qx, px);
    assign mag_y = abs_diff(r_qy, py);
    assign mag_z = abs_diff(r_qz, pz);

    // dimensions of zero behave as one: x always counts
    assign use_y   = (i_dims >= 2'd2);
    assign use_z   = (i_dims == 2'd3);
    assign sum     = SUM_BITS'(r_sq_x)
                   + (use_y ? SUM_BITS'(r_sq_y) : '0)
                   + (use_z ? SUM_BITS'(r_sq_z) : '0);
    assign sum_ext = DIST_BITS'(r_sum);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (wr_en) begin
                r_count <= r_count + 1'b1;
            end
            r_v1 <= i_cmd.rd_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_qx       <= i_word.coord_x;
            r_qy       <= i_word.coord_y;
            r_qz       <= i_word.coord_z;
            r_addr     <= '0;
            r_best     <= i_ceiling;
            r_best_idx <= '0;
        end else begin
            if (i_cmd.rd_issue) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_v4 && (sum_ext < r_best)) begin
                r_best     <= sum_ext;
                r_best_idx <= r_idx4;
            end
        end
        r_idx1  <= r_addr;
        r_idx2  <= r_idx1;
        r_idx3  <= r_idx2;
        r_idx4  <= r_idx3;
        r_mag_x <= mag_x;
        r_mag_y <= mag_y;
        r_mag_z <= mag_z;
        r_sq_x  <= SQ_BITS'(r_mag_x) * SQ_BITS'(r_mag_x);
        r_sq_y  <= SQ_BITS'(r_mag_y) * SQ_BITS'(r_mag_y);
        r_sq_z  <= SQ_BITS'(r_mag_z) * SQ_BITS'(r_mag_z);
        r_sum   <= sum;
        if (i_cmd.load_out) begin
            r_out.nearest_index <= r_best_idx;
            r_out.best_distance <= r_best;
        end
    end

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.last_addr = ({1'b0, r_addr} == (r_count - 1'b1));
    assign o_sts.pipe_busy = r_v1 || r_v2 || r_v3 || r_v4;
    assign o_word          = r_out;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_BITS'(MAX_POINTS))
        else $error("point count beyond table size");

    a_v1_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> $past(i_cmd.rd_issue))
        else $error("pipeline word without a table read");

    a_best_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_query |=> (r_best == $past(i_ceiling)) && (r_best_idx == '0))
        else $error("query did not start from the ceiling");
`endif

endmodule

@@ src/nearest_point_search_unit.sv @@
// ----------------------------------------------------------------------------
// nearest_point_search_unit
// Brute-force nearest point search over a table of up to 1024 points with
// three signed Q3.12 coordinates. An input word clears the table, appends a
// point (dropped when the table is full) or queries with a point; only a
// query returns a word: the index of the stored point with the smallest
// squared distance (Q12.24, summed over the configured number of
// coordinates), the first of equal ones, if that distance is strictly below
// the distance ceiling, plus that distance, or index 0 and the ceiling when
// no point qualifies. A query walks the table through the single read port
// of the point memory, one point per cycle, followed by a four-stage
// distance pipeline; the result is loaded once the pipeline is empty and the
// output register is free. The input stalls while a query runs; a finished
// result sits in its own output register, so new words are taken while it
// waits.
// Write configuration only while no query is in flight.
// ----------------------------------------------------------------------------
module nearest_point_search_unit
    import nps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_word             i_word,
    // result words
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_word            o_word,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [DIST_BITS-1:0] i_cfg_data
);

    logic [DIMS_BITS-1:0] r_dims;
    logic [DIST_BITS-1:0] r_ceiling;
    logic                 cfg_write;
    t_cmd                 cmd;
    t_sts                 sts;

    // Registers are always writable; the host keeps writes to idle periods.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims    <= DIMS_RESET;
            r_ceiling <= CEILING_RESET;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_DIMENSIONS: r_dims    <= i_cfg_data[DIMS_BITS-1:0];
                CFG_CEILING:    r_ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Controller: accepts words, sequences the table scan, owns output valid.
    nps_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_opcode (i_word.opcode),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (cmd),
        .i_sts    (sts)
    );

    // Datapath: point memory, distance pipeline, running best, output word.
    nps_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_word    (i_word),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_dims    (r_dims),
        .i_ceiling (r_ceiling),
        .o_word    (o_word)
    );

endmodule

@@ sim/tb_nearest_point_search_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_nearest_point_search_unit
// Self-checking bench for the nearest point search unit. A queue of input
// words, filled phase by phase, feeds a clocked driver. A clocked monitor
// checks every result word against the oldest prediction made from the bench's
// own copy of the point table and configuration. Both sides idle and stall at
// random. The receiver also holds off once for a long stretch so that the
// unit fills up.
// ----------------------------------------------------------------------------
module tb_nearest_point_search_unit;
    import nps_pkg::*;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    localparam logic [OP_BITS-1:0]   OP_UNUSED     = 2'd3;
    localparam t_coord               COORD_MIN     = 16'sh8000;
    localparam t_coord               COORD_MAX     = 16'sh7fff;
    localparam t_coord               COORD_ZERO    = 16'sh0000;
    localparam t_coord               COORD_ONE     = 16'sh1000;   // 1.0 in Q3.12
    localparam logic [DIST_BITS-1:0] DIST_MAX      = '1;
    localparam logic [DIST_BITS-1:0] DIST_ONE      = 36'd16777216; // 1.0 in Q12.24
    localparam int                   IDLE_PCT      = 24;
    localparam int                   HOLD_CYCLES   = 1500;
    localparam int                   SETTLE_CYCLES = 8;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    t_in_word             i_word      = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    t_out_word            o_word;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_index = CFG_DIMENSIONS;
    logic [DIST_BITS-1:0] i_cfg_data  = '0;

    // Bench copy of the unit's state
    t_coord               tbl_x [MAX_POINTS];
    t_coord               tbl_y [MAX_POINTS];
    t_coord               tbl_z [MAX_POINTS];
    int                   tbl_count   = 0;
    logic [DIMS_BITS-1:0] dims_reg    = DIMS_RESET;
    logic [DIST_BITS-1:0] ceiling_reg = CEILING_RESET;

    t_in_word             word_q [$];     // words waiting to be offered
    t_out_word            nearest_q [$];  // predicted answers, oldest first
    int                   errors       = 0;
    int                   words_sent   = 0;
    int                   results_seen = 0;
    int                   hold_left    = 0;
    bit                   held         = 1'b0;

    nearest_point_search_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_word      (i_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word      (o_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Update the table copy for one accepted word; queue the answer of a query.
    // Squares of 16-bit differences stay below 2^32, so the sum never saturates.
    function automatic void predict_nearest(input t_in_word w);
        longint unsigned best;
        longint unsigned acc;
        longint          diff;
        int              used;
        int              best_idx;
        t_coord          q [3];
        t_coord          p [3];
        t_out_word       ans;
        case (w.opcode)
            OP_CLEAR: begin
                tbl_count = 0;
            end
            OP_APPEND: begin
                // drop the point when the table is full
                if (tbl_count < MAX_POINTS) begin
                    tbl_x[tbl_count] = w.coord_x;
                    tbl_y[tbl_count] = w.coord_y;
                    tbl_z[tbl_count] = w.coord_z;
                    tbl_count++;
                end
            end
            OP_QUERY: begin
                used     = (dims_reg == 0) ? 1 : int'(dims_reg);
                best     = 64'(ceiling_reg);
                best_idx = 0;
                q[0] = w.coord_x;
                q[1] = w.coord_y;
                q[2] = w.coord_z;
                for (int i = 0; i < tbl_count; i++) begin
                    p[0] = tbl_x[i];
                    p[1] = tbl_y[i];
                    p[2] = tbl_z[i];
                    acc  = 0;
                    for (int j = 0; j < used; j++) begin
                        diff = longint'(q[j]) - longint'(p[j]);
                        acc += longint'(diff * diff);
                    end
                    // strict compare: the first of equal distances wins
                    if (acc < best) begin
                        best     = acc;
                        best_idx = i;
                    end
                end
                ans.nearest_index = best_idx[INDEX_BITS-1:0];
                ans.best_distance = best[DIST_BITS-1:0];
                nearest_q = {nearest_q, ans};
            end
            default: begin
                // unused opcode: no state change, no answer
            end
        endcase
    endfunction

    // Word driver: predict on acceptance, then offer the next queued word or idle.
    // No idling while words 250..329 go out, to run the unit back to back.
    always @(posedge i_clk) begin : drive_words
        bit pause;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_nearest(i_word);
                words_sent++;
            end
            if (!i_valid || !o_stall) begin
                pause = !(words_sent >= 250 && words_sent < 330) &&
                        ($urandom_range(0, 99) < IDLE_PCT);
                if (word_q.size() != 0 && !pause) begin
                    i_word  <= word_q.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall.
    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (nearest_q.size() == 0) begin
                    $display("%0t: result word with no query pending, actual %h",
                             $time, o_word);
                    errors++;
                end else begin
                    want = nearest_q.pop_front();
                    if (o_word.nearest_index !== want.nearest_index) begin
                        $display("%0t: nearest_index expected %0d actual %0d",
                                 $time, want.nearest_index, o_word.nearest_index);
                        errors++;
                    end
                    if (o_word.best_distance !== want.best_distance) begin
                        $display("%0t: best_distance expected %0d actual %0d",
                                 $time, want.best_distance, o_word.best_distance);
                        errors++;
                    end
                end
                results_seen++;
            end
            // Hold off once while plenty of words are queued, so the output
            // register fills, the next query stalls and the input backs up.
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!held && results_seen >= 20 && word_q.size() > 30) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                i_stall   <= 1'b1;
            end else if (results_seen >= 80 && results_seen < 130) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Track register writes in the bench copy.
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DIMENSIONS: dims_reg    <= i_cfg_data[DIMS_BITS-1:0];
                CFG_CEILING:    ceiling_reg <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    task automatic push_word(input logic [OP_BITS-1:0] op, input t_coord x, y, z);
        t_in_word w;
        w.opcode  = op;
        w.coord_x = x;
        w.coord_y = y;
        w.coord_z = z;
        word_q = {word_q, w};
    endtask

    // Mix of full-range, clustered and extreme coordinates.
    function automatic t_coord pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return t_coord'($urandom);
        if (r < 8)
            return t_coord'(int'($urandom_range(0, 4095)) - 2048);
        if (r == 8)
            return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
        return t_coord'(0);
    endfunction

    function automatic t_coord jitter(input t_coord c);
        return c + t_coord'($urandom_range(0, 16)) - t_coord'(8);
    endfunction

    task automatic write_reg(input logic idx, input logic [DIST_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [DIMS_BITS-1:0] dims,
                             input logic [DIST_BITS-1:0] ceiling);
        write_reg(CFG_DIMENSIONS, DIST_BITS'(dims));
        write_reg(CFG_CEILING, ceiling);
        @(negedge i_clk);
    endtask

    // Wait until every word is taken and answered, then let a trailing
    // clear or append finish before the next register write.
    task automatic drain();
        do @(negedge i_clk); while (word_q.size() != 0 || i_valid || nearest_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly clear / appends / queries sequences, some stray words.
    task automatic random_phase(input int n_words);
        t_coord              sx [$];
        t_coord              sy [$];
        t_coord              sz [$];
        int                  made;
        int                  k;
        int                  nq;
        int                  pick;
        logic [OP_BITS-1:0]  op;
        made = 0;
        while (made < n_words) begin
            if ($urandom_range(0, 9) < 8) begin
                sx.delete();
                sy.delete();
                sz.delete();
                push_word(OP_CLEAR, pick_coord(), pick_coord(), pick_coord());
                k = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
                for (int i = 0; i < k; i++) begin
                    if (i != 0 && $urandom_range(0, 7) == 0) begin
                        // duplicate an earlier point to exercise ties
                        pick = $urandom_range(0, i - 1);
                        sx = {sx, sx[pick]};
                        sy = {sy, sy[pick]};
                        sz = {sz, sz[pick]};
                    end else begin
                        sx = {sx, pick_coord()};
                        sy = {sy, pick_coord()};
                        sz = {sz, pick_coord()};
                    end
                    push_word(OP_APPEND, sx[i], sy[i], sz[i]);
                end
                nq = $urandom_range(1, 4);
                for (int i = 0; i < nq; i++) begin
                    if (k != 0 && $urandom_range(0, 2) != 0) begin
                        pick = $urandom_range(0, k - 1);
                        if ($urandom_range(0, 3) == 0)
                            push_word(OP_QUERY, sx[pick], sy[pick], sz[pick]);
                        else
                            push_word(OP_QUERY, jitter(sx[pick]), jitter(sy[pick]),
                                      jitter(sz[pick]));
                    end else begin
                        push_word(OP_QUERY, pick_coord(), pick_coord(), pick_coord());
                    end
                end
                made += 1 + k + nq;
            end else begin
                op = OP_BITS'($urandom_range(0, 3));
                push_word(op, t_coord'($urandom), t_coord'($urandom), t_coord'($urandom));
                if (op != OP_UNUSED)
                    made++;
            end
        end
    endtask

    initial begin : stimulus
        while (!i_rst_n) @(negedge i_clk);

        // Directed words at reset configuration (3 coordinates, ceiling 100.0)
        push_word(OP_QUERY,  COORD_ZERO, COORD_ZERO, COORD_ZERO);   // empty table
        push_word(OP_UNUSED, COORD_MAX, COORD_MIN, COORD_ONE);      // ignored
        push_word(OP_APPEND, COORD_MIN, COORD_MIN, COORD_MIN);
        push_word(OP_APPEND, COORD_MAX, COORD_MAX, COORD_MAX);
        push_word(OP_APPEND, COORD_ZERO, COORD_ZERO, COORD_ZERO);
        push_word(OP_APPEND, COORD_ZERO, COORD_ZERO, COORD_ZERO);   // duplicate
        push_word(OP_APPEND, COORD_ONE, COORD_ZERO, COORD_ZERO);
        push_word(OP_QUERY,  COORD_MAX, COORD_MAX, COORD_MAX);
        push_word(OP_QUERY,  COORD_MIN, COORD_MIN, COORD_MIN);
        push_word(OP_QUERY,  COORD_ZERO, COORD_ZERO, COORD_ZERO);   // first of equals
        push_word(OP_QUERY,  16'sh0800, COORD_ZERO, COORD_ZERO);    // tie between three
        push_word(OP_QUERY,  COORD_MAX, COORD_MIN, COORD_MAX);      // nothing qualifies
        push_word(OP_CLEAR,  COORD_MAX, COORD_MAX, COORD_MAX);
        push_word(OP_QUERY,  COORD_ONE, COORD_ONE, COORD_ONE);      // empty after clear
        push_word(OP_APPEND, COORD_MAX, COORD_ZERO, COORD_ZERO);
        push_word(OP_QUERY,  COORD_MIN, COORD_ZERO, COORD_ZERO);    // widest difference
        push_word(OP_UNUSED, COORD_MIN, COORD_ZERO, COORD_ZERO);
        push_word(OP_QUERY,  COORD_MAX, t_coord'(1), t_coord'(-1));
        drain();

        // Distance equal to the ceiling does not qualify; one below does
        configure(2'd1, DIST_ONE);
        push_word(OP_CLEAR,  COORD_ZERO, COORD_ZERO, COORD_ZERO);
        push_word(OP_APPEND, COORD_ZERO, COORD_MAX, COORD_MIN);
        push_word(OP_QUERY,  COORD_ONE, COORD_ZERO, COORD_ZERO);
        push_word(OP_QUERY,  COORD_ONE - t_coord'(1), t_coord'(5), t_coord'(5));
        push_word(OP_QUERY,  -COORD_ONE, COORD_MIN, COORD_MAX);
        drain();

        configure(2'd1, DIST_MAX);
        random_phase(120);
        drain();

        configure(2'd2, DIST_BITS'({$urandom, $urandom}));
        random_phase(80);
        drain();

        // zero dimensions behaves as one
        configure(2'd0, CEILING_RESET);
        random_phase(70);
        drain();

        // zero ceiling: every query answers index 0, distance 0
        configure(2'd3, '0);
        random_phase(40);
        drain();

        configure(2'd3, DIST_BITS'($urandom_range(0, 1 << 26)));
        random_phase(70);
        drain();

        configure(2'd2, CEILING_RESET);
        random_phase(100);
        drain();

        if (errors == 0)
            $display("nearest_point_search_unit test passed");
        else
            $display("nearest_point_search_unit test failed");
        $finish;
    end

    initial begin : watchdog
        #1000000;
        $display("nearest_point_search_unit test failed");
        $finish;
    end

endmodule

@@ nearest_point_search_unit.f @@
src/nps_pkg.sv
src/nps_ram.sv
src/nps_ctrl.sv
src/nps_dp.sv
src/nearest_point_search_unit.sv
sim/tb_nearest_point_search_unit.sv
